// ----- hdl/source_text_tokenizer_assert.svh -----
// Assertion macros shared by the tokenizer modules.
// Each macro expects signals named clock and reset in the enclosing module.
`ifndef SOURCE_TEXT_TOKENIZER_ASSERT_SVH
`define SOURCE_TEXT_TOKENIZER_ASSERT_SVH

// Same-cycle implication.
`define STT_ASSERT_NOW(label, cond, expr) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (expr)) \
      else $error("source_text_tokenizer: same-cycle check failed");

// Next-cycle implication.
`define STT_ASSERT_NEXT(label, cond, expr) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (expr)) \
      else $error("source_text_tokenizer: next-cycle check failed");

`endif

// ----- hdl/stt_pkg.sv -----
package stt_pkg;

   typedef struct packed {
      logic [7:0] char_code;
      logic       end_of_source;
   } req_type;

   typedef struct packed {
      logic [4:0]  token_kind;
      logic [4:0]  token_attr;
      logic [15:0] line_number;
      logic [15:0] start_pos;
      logic [15:0] token_length;
      logic        last_of_run;
   } rsp_type;

   // Tokens produced by one step: count is 0, 1 or 2, first goes out first.
   typedef struct packed {
      logic [1:0] count;
      rsp_type    first;
      rsp_type    second;
   } step_out_type;

   typedef struct packed {
      logic [4:0] kind;
      logic [4:0] attr;
   } tok_code_type;

   typedef struct packed {
      logic         hit;
      tok_code_type code;
   } pair_code_type;

   localparam logic [4:0] KIND_END      = 5'd0;
   localparam logic [4:0] KIND_IDENT    = 5'd1;
   localparam logic [4:0] KIND_NUMBER   = 5'd2;
   localparam logic [4:0] KIND_STRING   = 5'd3;
   localparam logic [4:0] KIND_COMMA    = 5'd4;
   localparam logic [4:0] KIND_DOT      = 5'd5;
   localparam logic [4:0] KIND_RANGE    = 5'd6;
   localparam logic [4:0] KIND_LAMBDA   = 5'd7;
   localparam logic [4:0] KIND_MAP      = 5'd8;
   localparam logic [4:0] KIND_FORRANGE = 5'd9;
   localparam logic [4:0] KIND_LPAREN   = 5'd10;
   localparam logic [4:0] KIND_RPAREN   = 5'd11;
   localparam logic [4:0] KIND_LBRACK   = 5'd12;
   localparam logic [4:0] KIND_RBRACK   = 5'd13;
   localparam logic [4:0] KIND_LBRACE   = 5'd14;
   localparam logic [4:0] KIND_RBRACE   = 5'd15;
   localparam logic [4:0] KIND_EXPOP    = 5'd16;
   localparam logic [4:0] KIND_MULOP    = 5'd17;
   localparam logic [4:0] KIND_ADDOP    = 5'd18;
   localparam logic [4:0] KIND_RELOP    = 5'd19;
   localparam logic [4:0] KIND_REGEX    = 5'd20;
   localparam logic [4:0] KIND_ASSIGN   = 5'd21;
   localparam logic [4:0] KIND_COLON    = 5'd22;
   localparam logic [4:0] KIND_SEMI     = 5'd23;
   localparam logic [4:0] KIND_NOT      = 5'd24;
   localparam logic [4:0] KIND_ERROR    = 5'd25;

   localparam logic [4:0] ATTR_DEFAULT = 5'd0;
   localparam logic [4:0] ATTR_REAL    = 5'd1;
   localparam logic [4:0] ATTR_INT     = 5'd2;
   localparam logic [4:0] ATTR_EQ      = 5'd3;
   localparam logic [4:0] ATTR_NEQ     = 5'd4;
   localparam logic [4:0] ATTR_GEQ     = 5'd5;
   localparam logic [4:0] ATTR_LEQ     = 5'd6;
   localparam logic [4:0] ATTR_GT      = 5'd7;
   localparam logic [4:0] ATTR_LT      = 5'd8;
   localparam logic [4:0] ATTR_MULT    = 5'd9;
   localparam logic [4:0] ATTR_AND     = 5'd10;
   localparam logic [4:0] ATTR_DIV     = 5'd11;
   localparam logic [4:0] ATTR_MOD     = 5'd12;
   localparam logic [4:0] ATTR_OR      = 5'd13;
   localparam logic [4:0] ATTR_ADD     = 5'd14;
   localparam logic [4:0] ATTR_SUB     = 5'd15;
   localparam logic [4:0] ATTR_EXP     = 5'd16;

   localparam logic [7:0] CHAR_NEWLINE    = 8'h0A;
   localparam logic [7:0] CHAR_TAB        = 8'h09;
   localparam logic [7:0] CHAR_VTAB       = 8'h0B;
   localparam logic [7:0] CHAR_RETURN     = 8'h0D;
   localparam logic [7:0] CHAR_SPACE      = 8'h20;
   localparam logic [7:0] CHAR_UNDERSCORE = 8'h5F;
   localparam logic [7:0] CHAR_QUOTE      = 8'h22;
   localparam logic [7:0] CHAR_HASH       = 8'h23;
   localparam logic [7:0] CHAR_DOT        = 8'h2E;

   function automatic logic is_digit(input logic [7:0] c);
      return c inside {["0":"9"]};
   endfunction

   function automatic logic is_word(input logic [7:0] c);
      return c inside {["0":"9"], ["a":"z"], ["A":"Z"], CHAR_UNDERSCORE};
   endfunction

   // Characters that may open a two-character operator.
   function automatic logic pairable(input logic [7:0] c);
      return c inside {"<", ">", "+", "-", "*", "/", "%", ":", "^", "="};
   endfunction

   // One-character token; an unknown byte maps to the error kind.
   function automatic tok_code_type single_tok(input logic [7:0] c);
      tok_code_type t;
      t.attr = ATTR_DEFAULT;
      case (c)
         ",": t.kind = KIND_COMMA;
         ".": t.kind = KIND_DOT;
         "@": t.kind = KIND_LAMBDA;
         "(": t.kind = KIND_LPAREN;
         ")": t.kind = KIND_RPAREN;
         "[": t.kind = KIND_LBRACK;
         "]": t.kind = KIND_RBRACK;
         "{": t.kind = KIND_LBRACE;
         "}": t.kind = KIND_RBRACE;
         "^": t.kind = KIND_EXPOP;
         ";": t.kind = KIND_SEMI;
         "!": t.kind = KIND_NOT;
         ":": t.kind = KIND_COLON;
         "&": begin t.kind = KIND_MULOP; t.attr = ATTR_AND;  end
         "*": begin t.kind = KIND_MULOP; t.attr = ATTR_MULT; end
         "/": begin t.kind = KIND_MULOP; t.attr = ATTR_DIV;  end
         "%": begin t.kind = KIND_MULOP; t.attr = ATTR_MOD;  end
         "|": begin t.kind = KIND_ADDOP; t.attr = ATTR_OR;   end
         "+": begin t.kind = KIND_ADDOP; t.attr = ATTR_ADD;  end
         "-": begin t.kind = KIND_ADDOP; t.attr = ATTR_SUB;  end
         "=": begin t.kind = KIND_RELOP; t.attr = ATTR_EQ;   end
         ">": begin t.kind = KIND_RELOP; t.attr = ATTR_GT;   end
         "<": begin t.kind = KIND_RELOP; t.attr = ATTR_LT;   end
         default: t.kind = KIND_ERROR;
      endcase
      return t;
   endfunction

   // Two-character operator from the held byte h and the next byte c.
   function automatic pair_code_type pair_tok(input logic [7:0] h, input logic [7:0] c);
      pair_code_type p;
      p.hit       = 1'b1;
      p.code.kind = KIND_ASSIGN;
      p.code.attr = ATTR_DEFAULT;
      if (h == "<" && c == "-") begin
         p.code.kind = KIND_FORRANGE;
      end else if (h == "<" && c == ">") begin
         p.code.kind = KIND_RELOP;
         p.code.attr = ATTR_NEQ;
      end else if (h == "<" && c == "=") begin
         p.code.kind = KIND_RELOP;
         p.code.attr = ATTR_LEQ;
      end else if (h == ">" && c == "=") begin
         p.code.kind = KIND_RELOP;
         p.code.attr = ATTR_GEQ;
      end else if (h == "-" && c == ">") begin
         p.code.kind = KIND_MAP;
      end else if (h == "=" && c == ">") begin
         p.code.kind = KIND_RANGE;
      end else if (c != "=") begin
         p.hit = 1'b0;
      end else begin
         case (h)
            "+":     p.code.attr = ATTR_ADD;
            "-":     p.code.attr = ATTR_SUB;
            "*":     p.code.attr = ATTR_MULT;
            "/":     p.code.attr = ATTR_DIV;
            "%":     p.code.attr = ATTR_MOD;
            "^":     p.code.attr = ATTR_EXP;
            ":":     p.code.attr = ATTR_DEFAULT;
            default: p.hit = 1'b0;
         endcase
      end
      return p;
   endfunction

   function automatic rsp_type make_tok(input logic [4:0] kind, input logic [4:0] attr,
                                        input logic [15:0] line, input logic [15:0] start,
                                        input logic [15:0] len);
      rsp_type t;
      t.token_kind   = kind;
      t.token_attr   = attr;
      t.line_number  = line;
      t.start_pos    = start;
      t.token_length = len;
      t.last_of_run  = 1'b0;
      return t;
   endfunction

endpackage

// ----- hdl/stt_step.sv -----
module stt_step #(
   parameter int SOURCE_SPAN = 65536
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  step_en,
   input  stt_pkg::req_type      item,
   output stt_pkg::step_out_type step
);
   import stt_pkg::*;

   localparam int POS_W = $clog2(SOURCE_SPAN);
   localparam logic [POS_W-1:0] POS_LAST = POS_W'(SOURCE_SPAN - 1);
   localparam logic [POS_W:0]   SPAN_V   = (POS_W+1)'(SOURCE_SPAN);

   typedef enum logic [6:0] {
      MODE_IDLE   = 7'b0000001,
      MODE_OP     = 7'b0000010,
      MODE_NUM    = 7'b0000100,
      MODE_IDENT  = 7'b0001000,
      MODE_STR    = 7'b0010000,
      MODE_REGEX  = 7'b0100000,
      MODE_BADNUM = 7'b1000000
   } mode_type;

   mode_type         mode_ff, mode_in;
   logic [7:0]       held_ff, held_in;
   logic [15:0]      line_ff, line_in;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic [POS_W-1:0] start_ff, start_in;
   logic             dot_ff, dot_in;

   function automatic logic [POS_W-1:0] next_pos(input logic [POS_W-1:0] p);
      return (p == POS_LAST) ? '0 : p + 1'b1;
   endfunction

   // Distance between two offsets on the wrapping span, clamped to 16 bits.
   function automatic logic [15:0] span_len(input logic [POS_W-1:0] from,
                                            input logic [POS_W-1:0] to);
      logic [POS_W:0] d;
      logic [31:0]    d32;
      if (to >= from) begin
         d = {1'b0, to} - {1'b0, from};
      end else begin
         d = SPAN_V - {1'b0, from} + {1'b0, to};
      end
      d32 = 32'(d);
      return (d32 > 32'd65535) ? 16'hFFFF : d32[15:0];
   endfunction

   logic [7:0]    c;
   logic [15:0]   start16, pos16, run_len, close_len;
   tok_code_type  held_code, char_code;
   pair_code_type pair_code;
   rsp_type       f_tok, s_tok;
   logic          f_vld, s_vld, fresh;

   assign c         = item.char_code;
   assign start16   = 16'(start_ff);
   assign pos16     = 16'(pos_ff);
   assign run_len   = span_len(start_ff, pos_ff);
   assign close_len = span_len(start_ff, next_pos(pos_ff));
   assign held_code = single_tok(held_ff);
   assign char_code = single_tok(c);
   assign pair_code = pair_tok(held_ff, c);

   always_comb begin
      mode_in  = mode_ff;
      held_in  = held_ff;
      line_in  = line_ff;
      pos_in   = pos_ff;
      start_in = start_ff;
      dot_in   = dot_ff;
      f_vld    = 1'b0;
      s_vld    = 1'b0;
      fresh    = 1'b1;
      f_tok    = '0;
      s_tok    = '0;
      if (item.end_of_source) begin
         // Flush whatever is pending, then the end token; state goes back to reset.
         case (mode_ff)
            MODE_OP: begin
               f_vld = 1'b1;
               f_tok = make_tok(held_code.kind, held_code.attr, line_ff, start16, 16'd1);
            end
            MODE_NUM: begin
               f_vld = 1'b1;
               f_tok = make_tok(KIND_NUMBER, dot_ff ? ATTR_REAL : ATTR_INT,
                                line_ff, start16, run_len);
            end
            MODE_IDENT: begin
               f_vld = 1'b1;
               f_tok = make_tok(KIND_IDENT, ATTR_DEFAULT, line_ff, start16, run_len);
            end
            MODE_BADNUM, MODE_STR, MODE_REGEX: begin
               f_vld = 1'b1;
               f_tok = make_tok(KIND_ERROR, ATTR_DEFAULT, line_ff, start16, run_len);
            end
            default: begin
            end
         endcase
         s_vld    = 1'b1;
         s_tok    = make_tok(KIND_END, ATTR_DEFAULT, line_ff, pos16, 16'd0);
         mode_in  = MODE_IDLE;
         held_in  = '0;
         line_in  = '0;
         pos_in   = '0;
         start_in = '0;
         dot_in   = 1'b0;
      end else begin
         case (mode_ff)
            MODE_OP: begin
               f_vld = 1'b1;
               if (pair_code.hit) begin
                  f_tok = make_tok(pair_code.code.kind, pair_code.code.attr,
                                   line_ff, start16, 16'd2);
                  fresh = 1'b0;
               end else begin
                  f_tok = make_tok(held_code.kind, held_code.attr, line_ff, start16, 16'd1);
               end
               mode_in = MODE_IDLE;
            end
            MODE_NUM: begin
               if (is_digit(c)) begin
                  fresh = 1'b0;
               end else if (c == CHAR_DOT) begin
                  if (dot_ff) begin
                     mode_in = MODE_BADNUM;
                  end
                  dot_in = 1'b1;
                  fresh  = 1'b0;
               end else begin
                  f_vld   = 1'b1;
                  f_tok   = make_tok(KIND_NUMBER, dot_ff ? ATTR_REAL : ATTR_INT,
                                     line_ff, start16, run_len);
                  mode_in = MODE_IDLE;
               end
            end
            MODE_BADNUM: begin
               if (is_digit(c) || c == CHAR_DOT) begin
                  fresh = 1'b0;
               end else begin
                  f_vld   = 1'b1;
                  f_tok   = make_tok(KIND_ERROR, ATTR_DEFAULT, line_ff, start16, run_len);
                  mode_in = MODE_IDLE;
               end
            end
            MODE_IDENT: begin
               if (is_word(c)) begin
                  fresh = 1'b0;
               end else begin
                  f_vld   = 1'b1;
                  f_tok   = make_tok(KIND_IDENT, ATTR_DEFAULT, line_ff, start16, run_len);
                  mode_in = MODE_IDLE;
               end
            end
            MODE_STR: begin
               fresh = 1'b0;
               if (c == CHAR_QUOTE) begin
                  f_vld   = 1'b1;
                  f_tok   = make_tok(KIND_STRING, ATTR_DEFAULT, line_ff, start16, close_len);
                  mode_in = MODE_IDLE;
               end
            end
            MODE_REGEX: begin
               fresh = 1'b0;
               if (c == CHAR_HASH) begin
                  f_vld   = 1'b1;
                  f_tok   = make_tok(KIND_REGEX, ATTR_DEFAULT, line_ff, start16, close_len);
                  mode_in = MODE_IDLE;
               end
            end
            default: mode_in = MODE_IDLE;
         endcase

         // A byte not absorbed by the token in progress starts something new.
         if (fresh) begin
            start_in = pos_ff;
            if (c == CHAR_NEWLINE) begin
               line_in = line_ff + 16'd1;
            end else if (c inside {CHAR_SPACE, CHAR_TAB, CHAR_VTAB, CHAR_RETURN}) begin
               // Whitespace makes no token.
            end else if (pairable(c)) begin
               held_in = c;
               mode_in = MODE_OP;
            end else if (is_digit(c)) begin
               dot_in  = 1'b0;
               mode_in = MODE_NUM;
            end else if (is_word(c)) begin
               mode_in = MODE_IDENT;
            end else if (c == CHAR_QUOTE) begin
               mode_in = MODE_STR;
            end else if (c == CHAR_HASH) begin
               mode_in = MODE_REGEX;
            end else begin
               s_vld = 1'b1;
               s_tok = make_tok(char_code.kind, char_code.attr, line_ff, pos16, 16'd1);
            end
         end
         pos_in = next_pos(pos_ff);
      end

      if (s_vld) begin
         s_tok.last_of_run = 1'b1;
      end else begin
         f_tok.last_of_run = f_vld;
      end
      step.count  = {1'b0, f_vld} + {1'b0, s_vld};
      step.first  = f_vld ? f_tok : s_tok;
      step.second = s_tok;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_IDLE;
         held_ff  <= '0;
         line_ff  <= '0;
         pos_ff   <= '0;
         start_ff <= '0;
         dot_ff   <= 1'b0;
      end else if (step_en) begin
         mode_ff  <= mode_in;
         held_ff  <= held_in;
         line_ff  <= line_in;
         pos_ff   <= pos_in;
         start_ff <= start_in;
         dot_ff   <= dot_in;
      end
   end

`include "source_text_tokenizer_assert.svh"

   `STT_ASSERT_NEXT(a_end_restarts, step_en && item.end_of_source, mode_ff == MODE_IDLE && pos_ff == '0 && line_ff == '0)
   `STT_ASSERT_NOW(a_end_emits, item.end_of_source, step.count != 2'd0 && step.second.token_kind == KIND_END)
   `STT_ASSERT_NOW(a_op_resolves, mode_ff == MODE_OP, step.count != 2'd0)

endmodule

// ----- hdl/stt_rsp_buf.sv -----
module stt_rsp_buf (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push_en,
   input  stt_pkg::step_out_type step,
   output logic [1:0]            room,
   input  logic                  rsp_ready,
   output logic                  rsp_valid,
   output stt_pkg::rsp_type      rsp_payload
);
   import stt_pkg::*;

   rsp_type    q0_ff, q0_in, q1_ff, q1_in;
   logic [1:0] cnt_ff, cnt_in;
   logic [1:0] keep, push_cnt;
   logic       pop;

   assign rsp_valid   = (cnt_ff != 2'd0);
   assign rsp_payload = q0_ff;
   assign pop         = rsp_valid && rsp_ready;
   assign keep        = cnt_ff - {1'b0, pop};
   assign room        = 2'd2 - keep;
   assign push_cnt    = push_en ? step.count : 2'd0;

   // Surviving entries move to the head, new tokens fill in behind them.
   always_comb begin
      cnt_in = keep + push_cnt;
      if (keep != 2'd0) begin
         q0_in = pop ? q1_ff : q0_ff;
      end else begin
         q0_in = step.first;
      end
      if (keep == 2'd2) begin
         q1_in = q1_ff;
      end else if (keep == 2'd1) begin
         q1_in = step.first;
      end else begin
         q1_in = step.second;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      q0_ff <= q0_in;
      q1_ff <= q1_in;
   end

`include "source_text_tokenizer_assert.svh"

   `STT_ASSERT_NOW(a_cnt_range, 1'b1, cnt_ff != 2'd3)
   `STT_ASSERT_NOW(a_no_overflow, push_en, {1'b0, keep} + {1'b0, push_cnt} <= 3'd2)
   `STT_ASSERT_NEXT(a_shift_order, pop && cnt_ff == 2'd2, rsp_payload == $past(q1_ff))

endmodule

// ----- hdl/source_text_tokenizer.sv -----
// Streaming tokenizer: one source byte (or an end marker) per req item, tokens out as rsp
// items carrying kind, attribute, line, start offset and length. A byte is taken every
// clock while results drain; the input register feeds the lexer step, whose tokens land
// in a two-entry result buffer, so a token is presented on rsp only after its byte has
// passed through both the input register and the result buffer.
// An item that produces two tokens (an end marker behind a pending token, or a byte that
// closes one token and is itself a one-byte token) leaves one token more in the buffer
// than the result port removes in that cycle. That extra token stays queued until an item
// that makes no token lets the buffer catch up, and while it is queued a further
// two-token item holds the input until both tokens fit. A stalled result port fills
// the buffer and then holds the input until room opens again.
// Operators that may take two bytes are resolved by holding their first byte until the
// next one arrives, so such a token comes out one item late. The end token always closes
// a text and carries last_of_run; after it the line and offset counters restart at zero.
// Offsets count modulo SOURCE_SPAN and lengths saturate at 65535.
module source_text_tokenizer #(
   parameter int SOURCE_SPAN = 65536
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  stt_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output stt_pkg::rsp_type rsp_payload
);
   import stt_pkg::*;

   // Input register: holds one accepted item until the lexer step can commit it.
   logic         in_valid_ff, in_valid_in;
   req_type      in_item_ff;
   step_out_type step;
   logic [1:0]   room;
   logic         advance;

   // The step commits only when every token it makes fits in the result buffer.
   assign advance     = in_valid_ff && (step.count <= room);
   assign req_ready   = !in_valid_ff || advance;
   assign in_valid_in = (req_valid && req_ready) || (in_valid_ff && !advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_item_ff <= req_payload;
      end
   end

   stt_step #(
      .SOURCE_SPAN(SOURCE_SPAN)
   ) u_step (
      .clock   (clock),
      .reset   (reset),
      .step_en (advance),
      .item    (in_item_ff),
      .step    (step)
   );

   stt_rsp_buf u_rsp_buf (
      .clock       (clock),
      .reset       (reset),
      .push_en     (advance),
      .step        (step),
      .room        (room),
      .rsp_ready   (rsp_ready),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload)
   );

endmodule

// ----- dv/tb.sv -----
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import stt_pkg::*;

   // Clock, reset and the two item channels of the tokenizer.
   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_payload = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_payload;

   source_text_tokenizer dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // A hard stop in case the block hangs: far beyond the slowest correct run.
   initial begin
      #12_000_000;
      $display("Verification failed");
      $finish;
   end

   // Lexer state as the testbench tracks it. The modes mirror what the block must
   // remember between bytes: an operator's first byte held for lookahead, a number,
   // a number that went bad on a second dot, an identifier, or an open literal.
   typedef enum logic [2:0] {
      LX_IDLE, LX_OP, LX_NUM, LX_IDENT, LX_STR, LX_REGEX, LX_BADNUM
   } lex_mode_type;

   lex_mode_type lx_mode  = LX_IDLE;
   logic [7:0]   lx_held  = '0;
   logic [15:0]  lx_line  = '0;
   logic [15:0]  lx_pos   = '0;
   logic [15:0]  lx_start = '0;
   logic         lx_dot   = 1'b0;

   // Tokens predicted but not yet seen on the result channel, oldest first.
   rsp_type pending_tokens[$];

   int   error_count = 0;
   int   tokens_seen = 0;
   int   bytes_sent  = 0;
   bit   gaps_on     = 1'b0;
   int   rsp_hold_cycles = 0;

   logic [7:0] text_bytes[$];

   // Every operator spelling the language knows, one- and two-byte.
   string op_spellings [36] = '{
      ",", ".", "@", "(", ")", "[", "]", "{", "}", "^", ";", "!", ":", "&", "*", "/",
      "%", "|", "+", "-", "=", ">", "<", "<-", "<>", "<=", ">=", "->", "=>", "+=",
      "-=", "*=", "/=", "%=", "^=", ":="
   };
   logic [7:0] blank_bytes [5] = '{CHAR_SPACE, CHAR_TAB, CHAR_VTAB, CHAR_RETURN, CHAR_NEWLINE};

   task automatic report_mismatch(input string msg);
      if (error_count < 200) $display("token %0d: %s", tokens_seen, msg);
      error_count++;
   endtask

   // ---------------------------------------------------------------------------------
   // Token prediction
   // ---------------------------------------------------------------------------------

   function automatic bit char_digit(input logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic bit char_word(input logic [7:0] c);
      return char_digit(c) || c == CHAR_UNDERSCORE || (c >= "a" && c <= "z") ||
             (c >= "A" && c <= "Z");
   endfunction

   // Bytes that might start a two-byte operator and therefore wait for lookahead.
   function automatic bit char_opener(input logic [7:0] c);
      case (c)
         "<", ">", "+", "-", "*", "/", "%", ":", "^", "=": return 1'b1;
         default: return 1'b0;
      endcase
   endfunction

   // Kind and attribute of a one-byte token; anything unknown is a lexical error.
   function automatic logic [9:0] lone_code(input logic [7:0] c);
      case (c)
         ",": return {KIND_COMMA,    ATTR_DEFAULT};
         ".": return {KIND_DOT,      ATTR_DEFAULT};
         "@": return {KIND_LAMBDA,   ATTR_DEFAULT};
         "(": return {KIND_LPAREN,   ATTR_DEFAULT};
         ")": return {KIND_RPAREN,   ATTR_DEFAULT};
         "[": return {KIND_LBRACK,   ATTR_DEFAULT};
         "]": return {KIND_RBRACK,   ATTR_DEFAULT};
         "{": return {KIND_LBRACE,   ATTR_DEFAULT};
         "}": return {KIND_RBRACE,   ATTR_DEFAULT};
         "^": return {KIND_EXPOP,    ATTR_DEFAULT};
         ";": return {KIND_SEMI,     ATTR_DEFAULT};
         "!": return {KIND_NOT,      ATTR_DEFAULT};
         ":": return {KIND_COLON,    ATTR_DEFAULT};
         "&": return {KIND_MULOP,    ATTR_AND};
         "*": return {KIND_MULOP,    ATTR_MULT};
         "/": return {KIND_MULOP,    ATTR_DIV};
         "%": return {KIND_MULOP,    ATTR_MOD};
         "|": return {KIND_ADDOP,    ATTR_OR};
         "+": return {KIND_ADDOP,    ATTR_ADD};
         "-": return {KIND_ADDOP,    ATTR_SUB};
         "=": return {KIND_RELOP,    ATTR_EQ};
         ">": return {KIND_RELOP,    ATTR_GT};
         "<": return {KIND_RELOP,    ATTR_LT};
         default: return {KIND_ERROR, ATTR_DEFAULT};
      endcase
   endfunction

   // Two-byte operator from the held byte and the next one; the top bit says whether
   // the pair forms an operator at all.
   function automatic logic [10:0] pair_code(input logic [7:0] h, input logic [7:0] c);
      case ({h, c})
         {"<", "-"}: return {1'b1, KIND_FORRANGE, ATTR_DEFAULT};
         {"<", ">"}: return {1'b1, KIND_RELOP,    ATTR_NEQ};
         {"<", "="}: return {1'b1, KIND_RELOP,    ATTR_LEQ};
         {">", "="}: return {1'b1, KIND_RELOP,    ATTR_GEQ};
         {"-", ">"}: return {1'b1, KIND_MAP,      ATTR_DEFAULT};
         {"=", ">"}: return {1'b1, KIND_RANGE,    ATTR_DEFAULT};
         {"+", "="}: return {1'b1, KIND_ASSIGN,   ATTR_ADD};
         {"-", "="}: return {1'b1, KIND_ASSIGN,   ATTR_SUB};
         {"*", "="}: return {1'b1, KIND_ASSIGN,   ATTR_MULT};
         {"/", "="}: return {1'b1, KIND_ASSIGN,   ATTR_DIV};
         {"%", "="}: return {1'b1, KIND_ASSIGN,   ATTR_MOD};
         {"^", "="}: return {1'b1, KIND_ASSIGN,   ATTR_EXP};
         {":", "="}: return {1'b1, KIND_ASSIGN,   ATTR_DEFAULT};
         default:    return {1'b0, KIND_ERROR,    ATTR_DEFAULT};
      endcase
   endfunction

   function automatic void expect_token(input logic [4:0] kind, input logic [4:0] attr,
                                        input logic [15:0] start, input logic [15:0] len);
      rsp_type t;
      t.token_kind   = kind;
      t.token_attr   = attr;
      t.line_number  = lx_line;
      t.start_pos    = start;
      t.token_length = len;
      t.last_of_run  = 1'b0;
      pending_tokens.push_back(t);
   endfunction

   // Advances the lexer by one accepted item and queues the tokens it must produce.
   // Offsets are 16 bits wide, so wrapping and length arithmetic come for free.
   function automatic void lex_step(input req_type item);
      logic [7:0]  c;
      logic [9:0]  one;
      logic [10:0] two;
      logic [15:0] run_len;
      bit          fresh;
      int          queued;
      c       = item.char_code;
      run_len = lx_pos - lx_start;
      fresh   = 1'b1;
      queued  = pending_tokens.size();
      if (item.end_of_source) begin
         // Flush whatever token is open, then close the text with the end token.
         case (lx_mode)
            LX_OP: begin
               one = lone_code(lx_held);
               expect_token(one[9:5], one[4:0], lx_start, 16'd1);
            end
            LX_NUM:   expect_token(KIND_NUMBER, lx_dot ? ATTR_REAL : ATTR_INT, lx_start,
                                   run_len);
            LX_IDENT: expect_token(KIND_IDENT, ATTR_DEFAULT, lx_start, run_len);
            LX_STR, LX_REGEX, LX_BADNUM:
               expect_token(KIND_ERROR, ATTR_DEFAULT, lx_start, run_len);
            default: ;
         endcase
         expect_token(KIND_END, ATTR_DEFAULT, lx_pos, 16'd0);
         lx_mode  = LX_IDLE;
         lx_held  = '0;
         lx_line  = '0;
         lx_pos   = '0;
         lx_start = '0;
         lx_dot   = 1'b0;
      end else begin
         case (lx_mode)
            LX_OP: begin
               two = pair_code(lx_held, c);
               if (two[10]) begin
                  expect_token(two[9:5], two[4:0], lx_start, 16'd2);
                  fresh = 1'b0;
               end else begin
                  one = lone_code(lx_held);
                  expect_token(one[9:5], one[4:0], lx_start, 16'd1);
               end
               lx_mode = LX_IDLE;
            end
            LX_NUM: begin
               if (char_digit(c)) begin
                  fresh = 1'b0;
               end else if (c == CHAR_DOT) begin
                  if (lx_dot) lx_mode = LX_BADNUM;
                  lx_dot = 1'b1;
                  fresh  = 1'b0;
               end else begin
                  expect_token(KIND_NUMBER, lx_dot ? ATTR_REAL : ATTR_INT, lx_start, run_len);
                  lx_mode = LX_IDLE;
               end
            end
            LX_BADNUM: begin
               if (char_digit(c) || c == CHAR_DOT) begin
                  fresh = 1'b0;
               end else begin
                  expect_token(KIND_ERROR, ATTR_DEFAULT, lx_start, run_len);
                  lx_mode = LX_IDLE;
               end
            end
            LX_IDENT: begin
               if (char_word(c)) begin
                  fresh = 1'b0;
               end else begin
                  expect_token(KIND_IDENT, ATTR_DEFAULT, lx_start, run_len);
                  lx_mode = LX_IDLE;
               end
            end
            LX_STR, LX_REGEX: begin
               // Everything up to the closing delimiter belongs to the literal,
               // newlines too, and the delimiter itself is part of the token.
               fresh = 1'b0;
               if (c == (lx_mode == LX_STR ? CHAR_QUOTE : CHAR_HASH)) begin
                  expect_token(lx_mode == LX_STR ? KIND_STRING : KIND_REGEX, ATTR_DEFAULT,
                               lx_start, lx_pos + 16'd1 - lx_start);
                  lx_mode = LX_IDLE;
               end
            end
            default: ;
         endcase
         if (fresh) begin
            lx_start = lx_pos;
            if (c == CHAR_NEWLINE) begin
               lx_line = lx_line + 16'd1;
            end else if (c == CHAR_SPACE || c == CHAR_TAB || c == CHAR_VTAB ||
                         c == CHAR_RETURN) begin
               // Blanks separate tokens and make none.
            end else if (char_opener(c)) begin
               lx_held = c;
               lx_mode = LX_OP;
            end else if (char_digit(c)) begin
               lx_dot  = 1'b0;
               lx_mode = LX_NUM;
            end else if (char_word(c)) begin
               lx_mode = LX_IDENT;
            end else if (c == CHAR_QUOTE) begin
               lx_mode = LX_STR;
            end else if (c == CHAR_HASH) begin
               lx_mode = LX_REGEX;
            end else begin
               one = lone_code(c);
               expect_token(one[9:5], one[4:0], lx_start, 16'd1);
            end
         end
         lx_pos = lx_pos + 16'd1;
      end
      // The last token an item causes carries the end-of-run flag.
      if (pending_tokens.size() > queued)
         pending_tokens[pending_tokens.size() - 1].last_of_run = 1'b1;
   endfunction

   // ---------------------------------------------------------------------------------
   // Channel drivers and the token checker
   // ---------------------------------------------------------------------------------

   // Idle lengths: mostly none or short, now and then a long one.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (!gaps_on || r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Offers one item and waits until the block takes it. Called at a rising edge;
   // valid stays high into the next call unless a gap follows.
   task automatic send_item(input req_type item);
      int gap;
      req_valid   <= 1'b1;
      req_payload <= item;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      lex_step(item);
      bytes_sent++;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic send_char(input logic [7:0] c);
      send_item('{char_code: c, end_of_source: 1'b0});
   endtask

   // The byte that rides along with an end marker must be ignored by the block.
   task automatic send_end(input logic [7:0] junk);
      send_item('{char_code: junk, end_of_source: 1'b1});
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) send_char(s[i]);
   endtask

   // Stops offering items and waits for every predicted token, then a few more cycles
   // so that a stray extra token would still show up as unexpected.
   task automatic drain_tokens();
      int guard;
      guard = 0;
      req_valid <= 1'b0;
      while (pending_tokens.size() != 0 && guard < 20000) begin
         @(posedge clock);
         guard++;
      end
      repeat (8) @(posedge clock);
      if (pending_tokens.size() != 0) begin
         report_mismatch($sformatf("%0d tokens never arrived", pending_tokens.size()));
         pending_tokens.delete();
      end
   endtask

   // Result side: after each accepted token the receiver may pause. A requested hold
   // keeps ready low for that many cycles, counted here, whatever the sender does.
   initial begin
      int quiet;
      quiet = 0;
      forever begin
         @(posedge clock);
         if (rsp_hold_cycles > 0) begin
            quiet = rsp_hold_cycles;
            rsp_hold_cycles = 0;
         end
         if (rsp_valid && rsp_ready && quiet == 0) quiet = pick_gap();
         if (quiet > 0) begin
            rsp_ready <= 1'b0;
            quiet--;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // Each token accepted is compared, field by field, against the oldest prediction.
   always @(posedge clock) begin : check_tokens
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_tokens.size() == 0) begin
            report_mismatch($sformatf("unexpected token, kind %0d start %0d",
                                      rsp_payload.token_kind, rsp_payload.start_pos));
         end else begin
            want = pending_tokens.pop_front();
            if (rsp_payload.token_kind !== want.token_kind)
               report_mismatch($sformatf("token_kind %0d, expected %0d",
                                         rsp_payload.token_kind, want.token_kind));
            if (rsp_payload.token_attr !== want.token_attr)
               report_mismatch($sformatf("token_attr %0d, expected %0d",
                                         rsp_payload.token_attr, want.token_attr));
            if (rsp_payload.line_number !== want.line_number)
               report_mismatch($sformatf("line_number %0d, expected %0d",
                                         rsp_payload.line_number, want.line_number));
            if (rsp_payload.start_pos !== want.start_pos)
               report_mismatch($sformatf("start_pos %0d, expected %0d",
                                         rsp_payload.start_pos, want.start_pos));
            if (rsp_payload.token_length !== want.token_length)
               report_mismatch($sformatf("token_length %0d, expected %0d",
                                         rsp_payload.token_length, want.token_length));
            if (rsp_payload.last_of_run !== want.last_of_run)
               report_mismatch($sformatf("last_of_run %0b, expected %0b",
                                         rsp_payload.last_of_run, want.last_of_run));
         end
         tokens_seen++;
      end
   end

   // ---------------------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------------------

   // Short texts aimed at the corner cases: an empty text, an identifier, numbers,
   // a string and a regex, blanks, a second dot, a lone '=', '+=' taking both bytes,
   // a newline inside a string, NUL and a high byte, an operator and a number left
   // open at the end, and a string that never closes.
   task automatic test_directed();
      gaps_on = 1'b1;
      send_end(8'h00);
      send_text("_z9 1.5 1..2\v+=");
      send_char(CHAR_RETURN);
      send_text("=\n\"a\nb\"#q#");
      send_char(8'h00);
      send_char(8'hFF);
      send_text("<");
      send_end(8'hFF);
      send_text("7");
      send_end(8'h5A);
      send_text("\"ab");
      send_end(8'hA5);
      drain_tokens();
   endtask

   // A long run of lines with no idling, so bytes go in at one per clock and the line
   // count climbs past the byte-wide range, followed by a string and an identifier.
   task automatic test_long_text();
      gaps_on = 1'b0;
      repeat (300) send_char(CHAR_NEWLINE);
      send_text("\"0123456789ab\"");
      repeat (10) send_char(CHAR_NEWLINE);
      send_text("x");
      send_end(8'h00);
      drain_tokens();
   endtask

   // The receiver holds off for a long stretch while the sender keeps offering bytes
   // that nearly all make a token, some of them two, so the block fills up and must stall.
   task automatic test_backpressure();
      gaps_on = 1'b0;
      rsp_hold_cycles = 150;
      repeat (20) send_text(",;a(");
      send_end(8'h00);
      drain_tokens();
   endtask

   function automatic logic [7:0] rand_digit();
      return 8'("0" + $urandom_range(0, 9));
   endfunction

   function automatic logic [7:0] word_byte(input bit lead);
      int r;
      r = $urandom_range(lead ? 10 : 0, 62);
      if (r < 10) return rand_digit();
      if (r < 36) return 8'("a" + r - 10);
      if (r < 62) return 8'("A" + r - 36);
      return CHAR_UNDERSCORE;
   endfunction

   // Builds one random text from well-formed tokens with random content, with some
   // noise bytes mixed in, and now and then a literal left open at the end.
   function automatic void compose_text();
      logic [7:0] closer;
      logic [7:0] b;
      string      op;
      text_bytes.delete();
      repeat ($urandom_range(1, 14)) begin
         case ($urandom_range(0, 10))
            0, 1: begin
               text_bytes.push_back(word_byte(1'b1));
               repeat ($urandom_range(0, 6)) text_bytes.push_back(word_byte(1'b0));
            end
            2: begin
               repeat ($urandom_range(1, 4)) text_bytes.push_back(rand_digit());
               if ($urandom_range(0, 1)) begin
                  text_bytes.push_back(CHAR_DOT);
                  repeat ($urandom_range(0, 3)) text_bytes.push_back(rand_digit());
                  if ($urandom_range(0, 5) == 0) begin
                     text_bytes.push_back(CHAR_DOT);
                     repeat ($urandom_range(0, 3)) text_bytes.push_back(rand_digit());
                  end
               end
            end
            3, 4: begin
               closer = $urandom_range(0, 1) ? CHAR_QUOTE : CHAR_HASH;
               text_bytes.push_back(closer);
               repeat ($urandom_range(0, 6)) begin
                  b = 8'($urandom_range(0, 255));
                  if (b == closer) b = "q";
                  if ($urandom_range(0, 5) == 0) b = CHAR_NEWLINE;
                  text_bytes.push_back(b);
               end
               text_bytes.push_back(closer);
            end
            5, 6, 7: begin
               op = op_spellings[$urandom_range(0, 35)];
               for (int i = 0; i < op.len(); i++) text_bytes.push_back(op[i]);
            end
            8, 9: text_bytes.push_back(blank_bytes[$urandom_range(0, 4)]);
            default: text_bytes.push_back(8'($urandom_range(0, 255)));
         endcase
      end
      if ($urandom_range(0, 9) == 0) begin
         closer = $urandom_range(0, 1) ? CHAR_QUOTE : CHAR_HASH;
         text_bytes.push_back(closer);
         repeat ($urandom_range(0, 4)) text_bytes.push_back(word_byte(1'b0));
      end
   endfunction

   // Random texts until about 1150 more items have gone in. Idling is switched off
   // for roughly one text in four so back-to-back stretches are covered too.
   task automatic test_random_texts();
      int target;
      target = bytes_sent + 1150;
      while (bytes_sent < target) begin
         gaps_on = ($urandom_range(0, 3) != 0);
         compose_text();
         foreach (text_bytes[i]) send_char(text_bytes[i]);
         send_end(8'($urandom_range(0, 255)));
      end
      drain_tokens();
   endtask

   // Reset once, run the tests in turn, then give the verdict.
   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_long_text();
      test_backpressure();
      test_random_texts();
      if (error_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
+incdir+hdl
hdl/stt_pkg.sv
hdl/stt_step.sv
hdl/stt_rsp_buf.sv
hdl/source_text_tokenizer.sv
dv/tb.sv
